// ===== design/dasd_pkg.sv =====
// ----------------------------------------------------------------------------
// dasd_pkg
// Shared types and constants for the two-axis step/direction generator.
// ----------------------------------------------------------------------------
package dasd_pkg;

  // internal width of positions, targets and step counts
  localparam int POS_W = 24;
  // width of the target and position fields on the ports
  localparam int FLD_W = 24;

  typedef enum logic [2:0] {
    ACT_TICK_A = 3'd0,
    ACT_TICK_B = 3'd1,
    ACT_SET    = 3'd2,
    ACT_HOME   = 3'd3,
    ACT_SEARCH = 3'd4,
    ACT_STOP   = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    MODE_HOME   = 2'd0,
    MODE_RUN    = 2'd1,
    MODE_SEARCH = 2'd2
  } mode_t;

  localparam logic [1:0] MOTOR_A = 2'd0;
  localparam logic [1:0] MOTOR_B = 2'd1;

  typedef struct packed {
    logic [2:0]              action;
    logic [1:0]              motor;
    logic signed [FLD_W-1:0] target;
    logic                    limit_a;
    logic                    limit_b;
  } in_item_t;

  typedef struct packed {
    logic                    step_a;
    logic                    dir_a;
    logic                    step_b;
    logic                    dir_b;
    logic                    tick_a_enabled;
    logic                    tick_b_enabled;
    logic [1:0]              mode_now;
    logic                    accepted;
    logic signed [FLD_W-1:0] position_a;
    logic signed [FLD_W-1:0] position_b;
  } out_item_t;

  // run-mode view of one axis
  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic signed [POS_W-1:0] tgt;
    logic                    new_move;
    logic                    tick_on;
    logic                    step;
    logic                    dir;
  } axis_t;

endpackage

// ===== design/dasd_core.sv =====
// ----------------------------------------------------------------------------
// dasd_core
// Axis state registers and the single-pass update for one request; the
// result reflects the state after the request.
// ----------------------------------------------------------------------------
module dasd_core
  import dasd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  in_item_t  item,
  output out_item_t res
);

  mode_t                   mode_r, mode_nxt;
  logic                    started_r, started_nxt;
  logic                    done_a_r, done_a_nxt;
  logic                    done_b_r, done_b_nxt;
  logic                    new_move_a_r, new_move_a_nxt;
  logic                    new_move_b_r, new_move_b_nxt;
  logic                    tick_a_on_r, tick_a_on_nxt;
  logic                    tick_b_on_r, tick_b_on_nxt;
  logic [1:0]              step_r, step_nxt;
  logic [1:0]              dir_r, dir_nxt;
  logic signed [POS_W-1:0] pos_a_r, pos_a_nxt;
  logic signed [POS_W-1:0] pos_b_r, pos_b_nxt;
  logic signed [POS_W-1:0] target_a_r, target_a_nxt;
  logic signed [POS_W-1:0] target_b_r, target_b_nxt;
  logic [POS_W-1:0]        low_r [2];
  logic [POS_W-1:0]        low_nxt [2];
  logic [POS_W-1:0]        high_r [2];
  logic [POS_W-1:0]        high_nxt [2];

  logic signed [POS_W-1:0] tval;
  logic                    accepted;
  logic                    search;
  axis_t                   ax_a, ax_b;

  function automatic axis_t run_tick(input axis_t a);
    axis_t o;
    o = a;
    if (a.new_move) begin
      o.dir      = (a.tgt > a.pos);
      o.new_move = 1'b0;
    end else if (a.pos == a.tgt) begin
      o.tick_on = 1'b0;
      o.step    = 1'b0;
    end else if (a.step) begin
      o.step = 1'b0;
    end else begin
      o.step = 1'b1;
      // position moves on the rising step edge
      if (a.tgt < a.pos) begin
        o.pos = a.pos - POS_W'(1);
      end else begin
        o.pos = a.pos + POS_W'(1);
      end
    end
    return o;
  endfunction

  always_comb begin
    mode_nxt       = mode_r;
    started_nxt    = started_r;
    done_a_nxt     = done_a_r;
    done_b_nxt     = done_b_r;
    new_move_a_nxt = new_move_a_r;
    new_move_b_nxt = new_move_b_r;
    tick_a_on_nxt  = tick_a_on_r;
    tick_b_on_nxt  = tick_b_on_r;
    step_nxt       = step_r;
    dir_nxt        = dir_r;
    pos_a_nxt      = pos_a_r;
    pos_b_nxt      = pos_b_r;
    target_a_nxt   = target_a_r;
    target_b_nxt   = target_b_r;
    low_nxt        = low_r;
    high_nxt       = high_r;
    accepted       = 1'b1;
    tval           = POS_W'(item.target);
    search         = (mode_r != MODE_HOME);
    ax_a           = '0;
    ax_b           = '0;

    unique case (item.action)
      ACT_TICK_A: begin
        if (tick_a_on_r) begin
          if (mode_r == MODE_RUN) begin
            ax_a = run_tick({pos_a_r, target_a_r, new_move_a_r, tick_a_on_r,
                             step_r[0], dir_r[0]});
            pos_a_nxt      = ax_a.pos;
            new_move_a_nxt = ax_a.new_move;
            tick_a_on_nxt  = ax_a.tick_on;
            step_nxt[0]    = ax_a.step;
            dir_nxt[0]     = ax_a.dir;
          end else begin
            if (!started_r) begin
              started_nxt = 1'b1;
              dir_nxt     = search ? 2'b00 : 2'b11;
            end else begin
              // axis A seek step
              if ((search ? !item.limit_a : item.limit_a) && !done_a_r) begin
                if (search) high_nxt[0] = high_r[0] + POS_W'(1);
                else        low_nxt[0]  = low_r[0] - POS_W'(1);
                step_nxt[0] = !step_r[0];
              end else begin
                done_a_nxt  = 1'b1;
                step_nxt[0] = 1'b0;
              end
              // axis B seek step, paced by the axis A timer
              if ((search ? !item.limit_b : item.limit_b) && !done_b_r) begin
                if (search) high_nxt[1] = high_r[1] + POS_W'(1);
                else        low_nxt[1]  = low_r[1] - POS_W'(1);
                step_nxt[1] = !step_r[1];
              end else begin
                done_b_nxt  = 1'b1;
                step_nxt[1] = 1'b0;
              end
            end
            if (done_a_nxt && done_b_nxt) begin
              mode_nxt = MODE_RUN;
              if (!search) begin
                pos_a_nxt    = '0;
                pos_b_nxt    = '0;
                target_a_nxt = '0;
                target_b_nxt = '0;
              end
              tick_a_on_nxt = 1'b0;
            end
          end
        end
      end
      ACT_TICK_B: begin
        if (tick_b_on_r) begin
          ax_b = run_tick({pos_b_r, target_b_r, new_move_b_r, tick_b_on_r,
                           step_r[1], dir_r[1]});
          pos_b_nxt      = ax_b.pos;
          new_move_b_nxt = ax_b.new_move;
          tick_b_on_nxt  = ax_b.tick_on;
          step_nxt[1]    = ax_b.step;
          dir_nxt[1]     = ax_b.dir;
        end
      end
      ACT_SET: begin
        if (item.motor == MOTOR_A) begin
          target_a_nxt   = tval;
          new_move_a_nxt = 1'b1;
          tick_a_on_nxt  = 1'b1;
        end else if (item.motor == MOTOR_B) begin
          target_b_nxt   = tval;
          new_move_b_nxt = 1'b1;
          tick_b_on_nxt  = 1'b1;
        end else begin
          accepted = 1'b0;
        end
      end
      ACT_HOME, ACT_SEARCH: begin
        tick_b_on_nxt = 1'b0;
        mode_nxt      = (item.action == ACT_HOME) ? MODE_HOME : MODE_SEARCH;
        done_a_nxt    = 1'b0;
        done_b_nxt    = 1'b0;
        started_nxt   = 1'b0;
        if (item.action == ACT_HOME) begin
          low_nxt[0] = '0;
          low_nxt[1] = '0;
        end else begin
          high_nxt[0] = '0;
          high_nxt[1] = '0;
        end
        tick_a_on_nxt = 1'b1;
      end
      ACT_STOP: begin
        target_a_nxt = pos_a_r;
        target_b_nxt = pos_b_r;
      end
      default: begin
      end
    endcase

    res.step_a         = step_nxt[0];
    res.dir_a          = dir_nxt[0];
    res.step_b         = step_nxt[1];
    res.dir_b          = dir_nxt[1];
    res.tick_a_enabled = tick_a_on_nxt;
    res.tick_b_enabled = tick_b_on_nxt;
    res.mode_now       = mode_nxt;
    res.accepted       = accepted;
    res.position_a     = FLD_W'(pos_a_nxt);
    res.position_b     = FLD_W'(pos_b_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_RUN;
      started_r    <= 1'b0;
      done_a_r     <= 1'b0;
      done_b_r     <= 1'b0;
      new_move_a_r <= 1'b0;
      new_move_b_r <= 1'b0;
      tick_a_on_r  <= 1'b0;
      tick_b_on_r  <= 1'b0;
      step_r       <= '0;
      dir_r        <= '0;
      pos_a_r      <= '0;
      pos_b_r      <= '0;
      target_a_r   <= '0;
      target_b_r   <= '0;
      low_r[0]     <= '0;
      low_r[1]     <= '0;
      high_r[0]    <= '0;
      high_r[1]    <= '0;
    end else if (en) begin
      mode_r       <= mode_nxt;
      started_r    <= started_nxt;
      done_a_r     <= done_a_nxt;
      done_b_r     <= done_b_nxt;
      new_move_a_r <= new_move_a_nxt;
      new_move_b_r <= new_move_b_nxt;
      tick_a_on_r  <= tick_a_on_nxt;
      tick_b_on_r  <= tick_b_on_nxt;
      step_r       <= step_nxt;
      dir_r        <= dir_nxt;
      pos_a_r      <= pos_a_nxt;
      pos_b_r      <= pos_b_nxt;
      target_a_r   <= target_a_nxt;
      target_b_r   <= target_b_nxt;
      low_r        <= low_nxt;
      high_r       <= high_nxt;
    end
  end

  a_home_arms_a: assert property (@(posedge clk) disable iff (!rst_n)
    en && item.action == ACT_HOME |=> tick_a_on_r && !tick_b_on_r && mode_r == MODE_HOME)
    else $error("homing request did not arm axis A timer");

  a_stop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    en && item.action == ACT_STOP |=>
      target_a_r == $past(pos_a_r) && target_b_r == $past(pos_b_r))
    else $error("stop did not copy positions to targets");

  a_idle_b_tick: assert property (@(posedge clk) disable iff (!rst_n)
    en && item.action == ACT_TICK_B && !tick_b_on_r |=> $stable(pos_b_r) && $stable(step_r))
    else $error("disabled axis B tick changed state");

  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    en |-> res.accepted == !(item.action == ACT_SET && item.motor[1]))
    else $error("accepted flag wrong");

endmodule

// ===== design/dual_axis_step_dir_generator_unit.sv =====
// ----------------------------------------------------------------------------
// dual_axis_step_dir_generator_unit
// Two-axis step/direction generator with homing, range search and run mode.
// ----------------------------------------------------------------------------
// path: a request is held in the input register, then its result in the result register
// throughput: one request per cycle while results are taken; the input register advances into the
//   result register whenever the result register is empty or being taken
// reset: synchronous active-low; run mode, all lines low, positions,
//   targets and counts zero, both tick sources disabled
module dual_axis_step_dir_generator_unit
  import dasd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      in_v_r;
  in_item_t  in_item_r;
  logic      out_v_r;
  out_item_t out_item_r;
  out_item_t res;
  logic      adv;

  assign adv      = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || adv;

  dasd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .item  (in_item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
    if (adv) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_item_r;

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the two-axis step/direction generator against its own prediction
// of line levels, tick enables, mode and positions, one result per request,
// with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import dasd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
  localparam logic [2:0] ACT_UNUSED_7 = 3'd7;
  localparam logic [1:0] MOTOR_BAD_2  = 2'd2;
  localparam logic [1:0] MOTOR_BAD_3  = 2'd3;

  localparam int ITEM_COUNT     = 1900;
  localparam int QUIET_FROM     = 1650;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_PRINTED    = 100;

  class step_dir_checker;
    mode_t                   mode;
    bit                      started;
    bit                      done[2];
    bit                      new_move[2];
    bit                      tick_on[2];
    bit [1:0]                step_lines;
    bit [1:0]                dir_lines;
    logic signed [POS_W-1:0] pos[2];
    logic signed [POS_W-1:0] tgt[2];
    out_item_t               line_levels_q[$];
    int                      error_count;
    int                      result_index;

    function new();
      mode       = MODE_RUN;
      started    = 1'b0;
      done       = '{1'b0, 1'b0};
      new_move   = '{1'b0, 1'b0};
      tick_on    = '{1'b0, 1'b0};
      step_lines = 2'b00;
      dir_lines  = 2'b00;
      pos        = '{'0, '0};
      tgt        = '{'0, '0};
      error_count  = 0;
      result_index = 0;
    endfunction

    function int pending();
      return line_levels_q.size();
    endfunction

    // one run-mode tick: first sets direction, then step toggles and moves; disables at the target
    function void run_axis(int ax);
      if (new_move[ax]) begin
        dir_lines[ax] = (tgt[ax] > pos[ax]);
        new_move[ax] = 1'b0;
      end else if (pos[ax] == tgt[ax]) begin
        tick_on[ax] = 1'b0;
        step_lines[ax] = 1'b0;
      end else if (step_lines[ax]) begin
        step_lines[ax] = 1'b0;
      end else begin
        step_lines[ax] = 1'b1;
        if (tgt[ax] < pos[ax]) pos[ax] = pos[ax] - 1;
        else pos[ax] = pos[ax] + 1;
      end
    endfunction

    function void seek_axis(int ax, bit lim, bit search);
      bit go;
      go = search ? !lim : lim;
      if (go && !done[ax]) begin
        step_lines[ax] = ~step_lines[ax];
      end else begin
        done[ax] = 1'b1;
        step_lines[ax] = 1'b0;
      end
    endfunction

    function void seek_tick(bit search, bit lim_a, bit lim_b);
      if (!started) begin
        started = 1'b1;
        dir_lines = search ? 2'b00 : 2'b11;
      end else begin
        seek_axis(0, lim_a, search);
        seek_axis(1, lim_b, search);
      end
      if (done[0] && done[1]) begin
        mode = MODE_RUN;
        // homing leaves the axes at the origin
        if (!search) begin
          pos = '{'0, '0};
          tgt = '{'0, '0};
        end
        tick_on[0] = 1'b0;
      end
    endfunction

    function void note_request(in_item_t req);
      out_item_t want;
      bit        acc;
      acc = 1'b1;
      case (req.action)
        ACT_TICK_A: begin
          if (tick_on[0]) begin
            case (mode)
              MODE_HOME: seek_tick(1'b0, req.limit_a, req.limit_b);
              MODE_RUN:  run_axis(0);
              default:   seek_tick(1'b1, req.limit_a, req.limit_b);
            endcase
          end
        end
        ACT_TICK_B: begin
          if (tick_on[1]) run_axis(1);
        end
        ACT_SET: begin
          if (req.motor == MOTOR_A) begin
            tgt[0] = req.target;
            new_move[0] = 1'b1;
            tick_on[0] = 1'b1;
          end else if (req.motor == MOTOR_B) begin
            tgt[1] = req.target;
            new_move[1] = 1'b1;
            tick_on[1] = 1'b1;
          end else begin
            acc = 1'b0;
          end
        end
        ACT_HOME, ACT_SEARCH: begin
          tick_on[1] = 1'b0;
          mode = (req.action == ACT_HOME) ? MODE_HOME : MODE_SEARCH;
          done = '{1'b0, 1'b0};
          started = 1'b0;
          tick_on[0] = 1'b1;
        end
        ACT_STOP: begin
          tgt[0] = pos[0];
          tgt[1] = pos[1];
        end
        default: begin
        end
      endcase
      want.step_a         = step_lines[0];
      want.dir_a          = dir_lines[0];
      want.step_b         = step_lines[1];
      want.dir_b          = dir_lines[1];
      want.tick_a_enabled = tick_on[0];
      want.tick_b_enabled = tick_on[1];
      want.mode_now       = mode;
      want.accepted       = acc;
      want.position_a     = pos[0];
      want.position_b     = pos[1];
      line_levels_q.push_back(want);
    endfunction

    task report(string msg);
      if (error_count < MAX_PRINTED) $display("MISMATCH: %s", msg);
      error_count++;
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got 0x%0h expected 0x%0h",
                         result_index, name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (line_levels_q.size() == 0) begin
        report($sformatf("result %0d arrived with no request outstanding", result_index));
      end else begin
        want = line_levels_q.pop_front();
        check_field("step_a", got.step_a, want.step_a);
        check_field("dir_a", got.dir_a, want.dir_a);
        check_field("step_b", got.step_b, want.step_b);
        check_field("dir_b", got.dir_b, want.dir_b);
        check_field("tick_a_enabled", got.tick_a_enabled, want.tick_a_enabled);
        check_field("tick_b_enabled", got.tick_b_enabled, want.tick_b_enabled);
        check_field("mode_now", got.mode_now, want.mode_now);
        check_field("accepted", got.accepted, want.accepted);
        check_field("position_a", got.position_a, want.position_a);
        check_field("position_b", got.position_b, want.position_b);
      end
      result_index++;
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  step_dir_checker sb = new();
  int sent = 0;
  bit quiet = 1'b0;
  int idle_cycles = 0;

  dual_axis_step_dir_generator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  function automatic bit rb();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic in_item_t make_req(logic [2:0] act, logic [1:0] mot,
                                        logic signed [FLD_W-1:0] tgt, bit la, bit lb);
    in_item_t req;
    req.action  = act;
    req.motor   = mot;
    req.target  = tgt;
    req.limit_a = la;
    req.limit_b = lb;
    return req;
  endfunction

  function automatic in_item_t noise_req();
    return make_req(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                    FLD_W'($urandom), rb(), rb());
  endfunction

  task automatic send(in_item_t req);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req);
    sent++;
    quiet = (sent >= QUIET_FROM);
  endtask

  // hold off new requests until every result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic signed [FLD_W-1:0] near_target(int ax);
    int d;
    d = $urandom_range(0, 16);
    return FLD_W'(sb.pos[ax] + d - 8);
  endfunction

  // arm one axis and tick it part or all of the way
  task automatic run_move(int ax);
    logic signed [FLD_W-1:0] t;
    int                      n;
    int                      r;
    logic [2:0]              own_tick;
    logic [2:0]              other_tick;
    own_tick   = ax ? ACT_TICK_B : ACT_TICK_A;
    other_tick = ax ? ACT_TICK_A : ACT_TICK_B;
    r = $urandom_range(0, 9);
    if (r < 7) t = near_target(ax);
    else if (r < 9) t = FLD_W'($urandom);
    else t = sb.pos[ax];
    send(make_req(ACT_SET, 2'(ax), t, rb(), rb()));
    n = $urandom_range(0, 22);
    repeat (n) begin
      r = $urandom_range(0, 19);
      if (r == 0) send(make_req(ACT_STOP, 2'($urandom), FLD_W'($urandom), rb(), rb()));
      else if (r < 4) send(make_req(other_tick, 2'($urandom), FLD_W'($urandom), rb(), rb()));
      else send(make_req(own_tick, 2'($urandom), FLD_W'($urandom), rb(), rb()));
    end
  endtask

  // homing or range search: limits hold the stepping level for a while
  task automatic seek_run(bit search);
    int na;
    int nb;
    int i;
    int r;
    int ax;
    bit go;
    go = !search;
    na = $urandom_range(0, 10);
    nb = $urandom_range(0, 10);
    send(make_req(search ? ACT_SEARCH : ACT_HOME, 2'($urandom), FLD_W'($urandom), rb(), rb()));
    for (i = 0; i <= ((na > nb) ? na : nb) + 2; i++) begin
      if ($urandom_range(0, 19) == 0) break;
      r = $urandom_range(0, 14);
      if (r == 0) begin
        send(make_req(ACT_TICK_B, 2'($urandom), FLD_W'($urandom), rb(), rb()));
      end else if (r == 1) begin
        ax = $urandom_range(0, 1);
        send(make_req(ACT_SET, 2'(ax), near_target(ax), rb(), rb()));
      end else if (r == 2) begin
        send(make_req(ACT_TICK_A, 2'($urandom), FLD_W'($urandom), rb(), rb()));
      end else begin
        send(make_req(ACT_TICK_A, 2'($urandom), FLD_W'($urandom),
                      (i <= na) ? go : !go, (i <= nb) ? go : !go));
      end
    end
  endtask

  task automatic directed_part();
    send(make_req(ACT_TICK_A, MOTOR_A, '0, 1'b0, 1'b0));
    send(make_req(ACT_TICK_B, MOTOR_B, '0, 1'b1, 1'b1));
    send(make_req(ACT_UNUSED_6, MOTOR_A, 24'sh7fffff, 1'b1, 1'b0));
    send(make_req(ACT_UNUSED_7, MOTOR_B, 24'sh800000, 1'b0, 1'b1));
    send(make_req(ACT_SET, MOTOR_BAD_2, 24'sh800000, 1'b0, 1'b0));
    send(make_req(ACT_SET, MOTOR_BAD_3, 24'sh7fffff, 1'b1, 1'b1));
    send(make_req(ACT_SET, MOTOR_A, 24'sh7fffff, 1'b0, 1'b0));
    repeat (3) send(make_req(ACT_TICK_A, MOTOR_A, '0, 1'b0, 1'b0));
    // stop pins the target, next tick sees position equal and disables
    send(make_req(ACT_STOP, MOTOR_A, '0, 1'b0, 1'b0));
    send(make_req(ACT_TICK_A, MOTOR_A, '0, 1'b0, 1'b0));
    send(make_req(ACT_SET, MOTOR_B, 24'sh800000, 1'b0, 1'b0));
    repeat (2) send(make_req(ACT_TICK_B, MOTOR_B, '0, 1'b0, 1'b0));
    send(make_req(ACT_HOME, MOTOR_A, '0, 1'b0, 1'b0));
    send(make_req(ACT_TICK_A, MOTOR_A, '0, 1'b1, 1'b1));
    send(make_req(ACT_TICK_A, MOTOR_A, '0, 1'b1, 1'b0));
    send(make_req(ACT_TICK_A, MOTOR_A, '0, 1'b0, 1'b1));
    // target set while searching, axis A keeps following the search
    send(make_req(ACT_SEARCH, MOTOR_A, '0, 1'b0, 1'b0));
    send(make_req(ACT_SET, MOTOR_B, 24'sd5, 1'b0, 1'b0));
    send(make_req(ACT_TICK_A, MOTOR_A, '0, 1'b0, 1'b0));
    send(make_req(ACT_TICK_A, MOTOR_A, '0, 1'b0, 1'b0));
    send(make_req(ACT_TICK_A, MOTOR_A, '0, 1'b1, 1'b1));
    send(make_req(ACT_TICK_B, MOTOR_B, '0, 1'b0, 1'b0));
  endtask

  initial begin
    int r;
    int k;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_part();
    wait_drained();
    while (sent < ITEM_COUNT) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        run_move($urandom_range(0, 1));
      end else if (r < 65) begin
        seek_run(1'b0);
      end else if (r < 80) begin
        seek_run(1'b1);
      end else if (r < 95) begin
        k = $urandom_range(1, 5);
        repeat (k) send(noise_req());
      end else begin
        wait_drained();
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
design/dasd_pkg.sv
design/dasd_core.sv
design/dual_axis_step_dir_generator_unit.sv
test/testbench.sv
